// File: rtl/srcap_pkg.sv
// Shared types, constants and helpers for the serial response capture block.
package srcap_pkg;

    // payload and register widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned INDEX_W   = 7;
    localparam int unsigned LENGTH_W  = 8;
    localparam int unsigned PAT_W     = 64;
    localparam int unsigned PLEN_W    = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W     = 64;

    // capture depth; index and length widths above are sized for it
    localparam int unsigned MAX_RESPONSE = 128;

    // register indexes on the config port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_PATTERN = 2'd0,
        CFG_START_LENGTH  = 2'd1,
        CFG_END_PATTERN   = 2'd2,
        CFG_END_LENGTH    = 2'd3
    } t_cfg_index;

    // fixed detector texts
    localparam int unsigned ERR_LEN   = 5;
    localparam int unsigned FRAME_LEN = 2;

    // "ERRO:" one byte per position
    function automatic logic [BYTE_W-1:0] err_byte(input logic [2:0] pos);
        logic [BYTE_W-1:0] b;
        case (pos)
            3'd0:    b = 8'h45;
            3'd1:    b = 8'h52;
            3'd2:    b = 8'h52;
            3'd3:    b = 8'h4F;
            3'd4:    b = 8'h3A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // "}]" one byte per position
    function automatic logic [BYTE_W-1:0] frame_byte(input logic [1:0] pos);
        logic [BYTE_W-1:0] b;
        case (pos)
            2'd0:    b = 8'h7D;
            2'd1:    b = 8'h5D;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // one result beat
    typedef struct packed {
        logic                body_active;
        logic                capture_valid;
        logic [INDEX_W-1:0]  capture_index;
        logic [BYTE_W-1:0]   capture_byte;
        logic                response_done;
        logic [LENGTH_W-1:0] response_length;
        logic                capture_overflow;
        logic                error_detected;
        logic                frame_end_detected;
    } t_result;

endpackage

// File: rtl/srcap_rx_if.sv
// Input channel: one received byte per beat.
interface srcap_rx_if;
    import srcap_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/srcap_rsp_if.sv
// Result channel: one capture result per beat.
interface srcap_rsp_if;
    import srcap_pkg::*;

    logic                valid;
    logic                ready;
    logic                body_active;
    logic                capture_valid;
    logic [INDEX_W-1:0]  capture_index;
    logic [BYTE_W-1:0]   capture_byte;
    logic                response_done;
    logic [LENGTH_W-1:0] response_length;
    logic                capture_overflow;
    logic                error_detected;
    logic                frame_end_detected;

    modport source (
        output valid, input ready,
        output body_active, output capture_valid, output capture_index,
        output capture_byte, output response_done, output response_length,
        output capture_overflow, output error_detected, output frame_end_detected
    );
    modport sink (
        input valid, output ready,
        input body_active, input capture_valid, input capture_index,
        input capture_byte, input response_done, input response_length,
        input capture_overflow, input error_detected, input frame_end_detected
    );
endinterface

// File: rtl/serial_response_capture.sv
// Serial response capture: start/end pattern hunt, body capture, fixed text detectors.
// An accepted byte passes the input register, then the result register, to its result beat.
// Throughput: one byte per cycle while the sink takes each result beat; the matcher state updates in one pass per byte.
// A full result register keeps taking bytes while the sink takes the held beat.
// Reset (synchronous, active low) clears all matchers and valids and loads the
// config registers with start/end pattern 0 and start/end length 1.
module serial_response_capture #(
    parameter int unsigned PATTERN_BYTES = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [srcap_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srcap_pkg::CFG_W-1:0]      i_cfg_data,
    srcap_rx_if.sink                         i_rx,
    srcap_rsp_if.source                      o_rsp
);
    import srcap_pkg::*;

    localparam int unsigned COUNT_LIMIT = MAX_RESPONSE + PATTERN_BYTES;
    localparam int unsigned CNT_W       = $clog2(COUNT_LIMIT + 1);

    localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(MAX_RESPONSE);
    localparam logic [CNT_W-1:0]   CNT_LIMIT = CNT_W'(COUNT_LIMIT);
    localparam logic [INDEX_W-1:0] IDX_SAT   = INDEX_W'(MAX_RESPONSE - 1);
    localparam logic [PLEN_W-1:0]  PLEN_MAX  = PLEN_W'(PATTERN_BYTES);
    localparam logic [2:0]         ERR_LAST  = 3'(ERR_LEN - 1);
    localparam logic [1:0]         FRM_LAST  = 2'(FRAME_LEN - 1);

    // config registers
    logic [PAT_W-1:0]  r_start_pattern;
    logic [PLEN_W-1:0] r_start_length;
    logic [PAT_W-1:0]  r_end_pattern;
    logic [PLEN_W-1:0] r_end_length;

    // matcher state
    logic [PLEN_W-1:0] r_start_pos, n_start_pos;
    logic              r_in_body, n_in_body;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [PLEN_W-1:0] r_end_pos, n_end_pos;
    logic              r_ovf, n_ovf;
    logic [2:0]        r_err_pos, n_err_pos;
    logic [1:0]        r_frm_pos, n_frm_pos;

    // pipeline
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_out_valid;
    t_result           r_res, n_res;
    logic              s1_adv;

    // handshake
    assign s1_adv      = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_rx.ready  = !r_s1_valid || s1_adv;
    assign o_rsp.valid = r_out_valid;

    // clamp a pattern length to 1..PATTERN_BYTES
    function automatic logic [PLEN_W-1:0] clamp_len(input logic [PLEN_W-1:0] len);
        logic [PLEN_W-1:0] v;
        if (len == '0) begin
            v = PLEN_W'(1);
        end else if (len > PLEN_MAX) begin
            v = PLEN_MAX;
        end else begin
            v = len;
        end
        return v;
    endfunction

    // per-byte matcher pass
    always_comb begin
        logic [BYTE_W-1:0] b;
        logic [PLEN_W-1:0] slen;
        logic [PLEN_W-1:0] elen;
        logic [PLEN_W-1:0] pos_inc;
        logic [CNT_W-1:0]  len;
        logic              err_done;

        b    = r_s1_byte;
        slen = clamp_len(r_start_length);
        elen = clamp_len(r_end_length);

        n_res       = '0;
        n_start_pos = r_start_pos;
        n_in_body   = r_in_body;
        n_count     = r_count;
        n_end_pos   = r_end_pos;
        n_ovf       = r_ovf;
        n_frm_pos   = r_frm_pos;
        pos_inc     = '0;
        len         = '0;
        err_done    = 1'b0;

        // error text
        if (r_err_pos < 3'(ERR_LEN) && b == err_byte(r_err_pos)) begin
            n_err_pos = r_err_pos + 3'd1;
            err_done  = (r_err_pos == ERR_LAST);
        end else begin
            n_err_pos = '0;
        end

        // frame end text
        if (r_frm_pos < 2'(FRAME_LEN) && b == frame_byte(r_frm_pos)) begin
            if (r_frm_pos == FRM_LAST) begin
                n_frm_pos                = '0;
                n_res.frame_end_detected = 1'b1;
            end else begin
                n_frm_pos = r_frm_pos + 2'd1;
            end
        end else begin
            n_frm_pos = '0;
        end

        if (!r_in_body) begin
            // start hunt
            if (r_start_pos < slen
                && b == r_start_pattern[{r_start_pos[2:0], 3'b000} +: BYTE_W]) begin
                pos_inc = r_start_pos + PLEN_W'(1);
                if (pos_inc >= slen) begin
                    n_in_body   = 1'b1;
                    n_start_pos = '0;
                    n_count     = '0;
                    n_end_pos   = '0;
                    n_ovf       = 1'b0;
                end else begin
                    n_start_pos = pos_inc;
                end
            end else begin
                n_start_pos = '0;
            end
        end else begin
            // body capture
            n_res.body_active  = 1'b1;
            n_res.capture_byte = b;
            if (r_count < CNT_MAX) begin
                n_res.capture_valid = 1'b1;
                n_res.capture_index = INDEX_W'(r_count);
            end else begin
                n_ovf               = 1'b1;
                n_res.capture_index = IDX_SAT;
            end
            if (r_count < CNT_LIMIT) begin
                n_count = r_count + CNT_W'(1);
            end
            n_res.capture_overflow = n_ovf;

            // terminator match
            if (r_end_pos < elen
                && b == r_end_pattern[{r_end_pos[2:0], 3'b000} +: BYTE_W]) begin
                pos_inc = r_end_pos + PLEN_W'(1);
                if (pos_inc >= elen) begin
                    if (n_count >= CNT_W'(elen)) begin
                        len = n_count - CNT_W'(elen);
                    end
                    if (len > CNT_MAX) begin
                        len = CNT_MAX;
                    end
                    n_res.response_done   = 1'b1;
                    n_res.response_length = LENGTH_W'(len);
                    n_in_body   = 1'b0;
                    n_count     = '0;
                    n_end_pos   = '0;
                    n_start_pos = '0;
                    n_ovf       = 1'b0;
                end else begin
                    n_end_pos = pos_inc;
                end
            end else begin
                n_end_pos = '0;
            end
        end

        // error text wins over everything
        if (err_done) begin
            n_res                = '0;
            n_res.error_detected = 1'b1;
            n_start_pos          = '0;
            n_in_body            = 1'b0;
            n_count              = '0;
            n_end_pos            = '0;
            n_ovf                = 1'b0;
            n_err_pos            = '0;
            n_frm_pos            = '0;
        end
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pattern <= '0;
            r_start_length  <= PLEN_W'(1);
            r_end_pattern   <= '0;
            r_end_length    <= PLEN_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_START_PATTERN: r_start_pattern <= i_cfg_data;
                CFG_START_LENGTH:  r_start_length  <= i_cfg_data[PLEN_W-1:0];
                CFG_END_PATTERN:   r_end_pattern   <= i_cfg_data;
                CFG_END_LENGTH:    r_end_length    <= i_cfg_data[PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // control state and valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_start_pos <= '0;
            r_in_body   <= 1'b0;
            r_count     <= '0;
            r_end_pos   <= '0;
            r_ovf       <= 1'b0;
            r_err_pos   <= '0;
            r_frm_pos   <= '0;
        end else begin
            if (i_rx.ready) begin
                r_s1_valid <= i_rx.valid;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_start_pos <= n_start_pos;
                r_in_body   <= n_in_body;
                r_count     <= n_count;
                r_end_pos   <= n_end_pos;
                r_ovf       <= n_ovf;
                r_err_pos   <= n_err_pos;
                r_frm_pos   <= n_frm_pos;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_s1_byte <= i_rx.rx_byte;
        end
        if (s1_adv) begin
            r_res <= n_res;
        end
    end

    // result beat
    assign o_rsp.body_active        = r_res.body_active;
    assign o_rsp.capture_valid      = r_res.capture_valid;
    assign o_rsp.capture_index      = r_res.capture_index;
    assign o_rsp.capture_byte       = r_res.capture_byte;
    assign o_rsp.response_done      = r_res.response_done;
    assign o_rsp.response_length    = r_res.response_length;
    assign o_rsp.capture_overflow   = r_res.capture_overflow;
    assign o_rsp.error_detected     = r_res.error_detected;
    assign o_rsp.frame_end_detected = r_res.frame_end_detected;

endmodule
